[sv/cfp_pkg.sv]
package cfp_pkg;

    localparam logic [7:0] HDR_RECT   = 8'h40;
    localparam logic [7:0] HDR_TARGET = 8'h60;
    localparam logic [7:0] HDR_CMD    = 8'h20;
    localparam logic [7:0] TRL_RECT   = 8'h50;
    localparam logic [7:0] TRL_TARGET = 8'h70;
    localparam logic [7:0] NOT_FOUND  = 8'hAA;

    // r_count values at which the last byte of a frame arrives
    localparam logic [2:0] COORD_LAST = 3'd5;
    localparam logic [2:0] CMD_LAST   = 3'd3;

    localparam logic [1:0] KIND_FOUND     = 2'd0;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd1;
    localparam logic [1:0] KIND_TARGET    = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_COORD = 2'd1,
        MODE_CMD   = 2'd2
    } t_mode;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
    } t_result;

endpackage

[sv/coordinate_frame_parser_core.sv]
// Coordinate frame parser: takes one received byte per transaction and
// delivers one result per well-formed coordinate frame (header 0x40 or 0x60,
// four payload bytes, matching trailer 0x50 or 0x70). Command frames (0x20,
// four bytes), bad-trailer frames and stray bytes give nothing. A byte is
// accepted every cycle; the result appears in the output register in the cycle
// after the trailer byte is taken, and the input stalls only while that
// register holds a result the sink has not yet taken.
module coordinate_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte[7:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // coord_x[15:0], coord_y[31:16]
    output logic [1:0]  o_m_axis_tuser    // frame_kind[1:0]
);

    logic             take;
    cfp_pkg::t_result result;
    logic             r_out_valid;
    logic [1:0]       r_kind;
    logic [15:0]      r_x;
    logic [15:0]      r_y;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    cfp_frame_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (i_s_axis_tdata),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_kind <= result.kind;
            r_x    <= result.x;
            r_y    <= result.y;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_y, r_x};
    assign o_m_axis_tuser  = r_kind;

    // a result only follows an accepted trailer byte
    a_rise_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(take))
        else $error("result without accepted byte");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == cfp_pkg::KIND_FOUND ||
                             o_m_axis_tuser == cfp_pkg::KIND_NOT_FOUND ||
                             o_m_axis_tuser == cfp_pkg::KIND_TARGET))
        else $error("unused frame kind");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == cfp_pkg::KIND_NOT_FOUND)
            |-> (o_m_axis_tdata == 32'd0))
        else $error("not-found frame with coordinates");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled with free output register");

endmodule

[sv/cfp_frame_parser.sv]
module cfp_frame_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_byte,
    output cfp_pkg::t_result     o_result
);

    cfp_pkg::t_mode r_mode, n_mode;
    logic [2:0]     r_count, n_count;
    logic [7:0]     r_store [0:4];
    logic           store_we;

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_count  = r_count;
        store_we = 1'b0;
        unique case (r_mode)
            cfp_pkg::MODE_IDLE: begin
                if (i_byte == cfp_pkg::HDR_RECT || i_byte == cfp_pkg::HDR_TARGET) begin
                    n_mode   = cfp_pkg::MODE_COORD;
                    n_count  = 3'd1;
                    store_we = 1'b1;
                end else if (i_byte == cfp_pkg::HDR_CMD) begin
                    n_mode   = cfp_pkg::MODE_CMD;
                    n_count  = 3'd1;
                end
            end
            cfp_pkg::MODE_COORD: begin
                if (r_count >= cfp_pkg::COORD_LAST) begin
                    n_mode  = cfp_pkg::MODE_IDLE;
                    n_count = 3'd0;
                end else begin
                    n_count  = r_count + 3'd1;
                    store_we = 1'b1;
                end
            end
            cfp_pkg::MODE_CMD: begin
                if (r_count >= cfp_pkg::CMD_LAST) begin
                    n_mode  = cfp_pkg::MODE_IDLE;
                    n_count = 3'd0;
                end else begin
                    n_count = r_count + 3'd1;
                end
            end
            default: begin
                n_mode  = cfp_pkg::MODE_IDLE;
                n_count = 3'd0;
            end
        endcase
    end

    // result on the trailer byte
    always_comb begin
        o_result       = '0;
        o_result.x     = {r_store[1], r_store[2]};
        o_result.y     = {r_store[3], r_store[4]};
        o_result.kind  = cfp_pkg::KIND_FOUND;
        if (r_mode == cfp_pkg::MODE_COORD && r_count >= cfp_pkg::COORD_LAST) begin
            if (r_store[0] == cfp_pkg::HDR_RECT && i_byte == cfp_pkg::TRL_RECT) begin
                o_result.valid = i_take;
                if (r_store[1] == cfp_pkg::NOT_FOUND && r_store[2] == cfp_pkg::NOT_FOUND &&
                    r_store[3] == cfp_pkg::NOT_FOUND && r_store[4] == cfp_pkg::NOT_FOUND) begin
                    o_result.kind = cfp_pkg::KIND_NOT_FOUND;
                    o_result.x    = '0;
                    o_result.y    = '0;
                end
            end else if (r_store[0] == cfp_pkg::HDR_TARGET && i_byte == cfp_pkg::TRL_TARGET) begin
                o_result.valid = i_take;
                o_result.kind  = cfp_pkg::KIND_TARGET;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cfp_pkg::MODE_IDLE;
            r_count <= 3'd0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && store_we) begin
            if (r_mode == cfp_pkg::MODE_IDLE) begin
                r_store[0] <= i_byte;
            end else begin
                r_store[r_count] <= i_byte;
            end
        end
    end

endmodule
